### src/frame_step_timer_core_defines.svh
// Assertion macros used by the frame step timer checker.
`ifndef FRAME_STEP_TIMER_CORE_DEFINES_SVH
`define FRAME_STEP_TIMER_CORE_DEFINES_SVH

// Concurrent check on clk, ignored while reset is asserted.
`define FST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frame step timer check failed");

// Concurrent check on clk that also holds through reset.
`define FST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("frame step timer check failed during reset");

`endif

### src/fst_pkg.sv
// Types and constants of the frame step timer.
`timescale 1ns / 1ps

package fst_pkg;

    localparam int FREQ_W      = 32;
    localparam int MD_W        = 29;
    localparam int STAMP_W     = 64;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXD = 4'd1;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
    localparam logic [MD_W-1:0]   MAXD_RESET = 29'd1000000;

    // item actions
    localparam logic ACT_FRAME   = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef struct packed {
        logic               action;
        logic [STAMP_W-1:0] timestamp;
    } item_t;

    typedef struct packed {
        logic [STAMP_W-1:0] elapsed_ticks;
        logic [STAMP_W-1:0] total_ticks;
        logic [CNT_W-1:0]   frame_total;
        logic [CNT_W-1:0]   frames_per_second;
        logic               rate_updated;
    } result_t;

endpackage

### src/frame_step_timer_core.sv
// Frame step timer: bit-serial delta, scale by a constant, restoring divide.
`timescale 1ns / 1ps
// A restart transaction goes straight to the done state; a frame transaction passes through
// serial subtract/accumulate, shift-add multiply, divide, and serial tick sum and window
// modulo in a datapath that works one bit per cycle. One item is in flight at a time, and
// a finished result waits in the done state while a stalled output register is still full.
// Reset (rst_n, async, active low) clears all timing state and loads register defaults.

module frame_step_timer_core #(
    parameter int unsigned TICKS_PER_SECOND = 10000000
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // item channel
    input  logic                             item_valid,
    output logic                             item_stall,
    input  fst_pkg::item_t                   item,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output fst_pkg::result_t                 result,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fst_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fst_pkg::*;

    // Scale constant and product width follow from the tick rate.
    localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int HI_W  = TPS_W + 1;
    localparam int P_W   = HI_W + MD_W;
    localparam logic [TPS_W-1:0] TPS_VAL = TPS_W'(TICKS_PER_SECOND);

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_LAST = 6'd63;
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,    // delta = stamp - last, accum += delta, both compares
        ST_MUL,     // clamped delta * TICKS_PER_SECOND
        ST_DIV,     // product / frequency
        ST_FIN,     // tick sum add, accum % frequency
        ST_DONE     // hand result to the output register
    } state_t;

    state_t state_reg;
    logic [STEP_W-1:0] step_reg;

    // configuration
    logic [FREQ_W-1:0] freq_reg;
    logic [MD_W-1:0]   maxd_reg;

    // architectural state
    logic [STAMP_W-1:0] last_stamp_reg;
    logic [STAMP_W-1:0] accum_reg;
    logic [STAMP_W-1:0] tick_sum_reg;
    logic [STAMP_W-1:0] elapsed_reg;
    logic [CNT_W-1:0]   frame_cnt_reg;
    logic [CNT_W-1:0]   win_frames_reg;
    logic [CNT_W-1:0]   rate_reg;
    logic               closed_reg;

    // serial datapath
    logic [STAMP_W-1:0] stamp_sh_reg;
    logic [STAMP_W-1:0] delta_reg;
    logic [FREQ_W-1:0]  freq_sh_reg;
    logic [MD_W-1:0]    maxd_sh_reg;
    logic               borrow_reg;
    logic               carry_reg;
    logic               gt_reg;
    logic               ge_reg;
    logic [P_W-1:0]     mul_reg;
    logic [STAMP_W-1:0] dv_reg;
    logic [FREQ_W-1:0]  rem_reg;

    // output register
    logic    result_valid_reg;
    result_t result_reg;

    // combinational next values
    logic [FREQ_W-1:0]  freq_eff;
    logic [1:0]         diff2;
    logic [1:0]         sum2;
    logic [1:0]         tsum2;
    logic               d_bit;
    logic               acc_bit;
    logic               gt_next;
    logic               ge_next;
    logic [HI_W-1:0]    hi_next;
    logic [P_W-1:0]     mul_next;
    logic [FREQ_W:0]    shifted;
    logic [FREQ_W+1:0]  trial;
    logic               q_bit;
    logic [FREQ_W-1:0]  rem_next;
    logic [STAMP_W-1:0] dv_next;
    logic [MD_W-1:0]    mplier_next;
    logic               load_result;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // finished result moves to the output register once that register is free
    assign load_result  = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        // a zero frequency behaves as one
        freq_eff = (freq_reg == '0) ? FREQ_W'(1) : freq_reg;

        // serial subtract, LSB first
        diff2 = {1'b0, stamp_sh_reg[0]} - {1'b0, last_stamp_reg[0]} - {1'b0, borrow_reg};
        d_bit = diff2[0];
        // serial accumulate of the unclamped delta
        sum2    = {1'b0, accum_reg[0]} + {1'b0, d_bit} + {1'b0, carry_reg};
        acc_bit = sum2[0];
        // LSB-first magnitude compares: last differing bit decides
        gt_next = (d_bit != maxd_sh_reg[0]) ? d_bit : gt_reg;
        ge_next = (acc_bit != freq_sh_reg[0]) ? acc_bit : ge_reg;
        // clamp, using the delta bits as they stand after the final shift
        mplier_next = gt_next ? maxd_reg : delta_reg[MD_W:1];

        // shift-add multiply step
        hi_next  = mul_reg[P_W-1:MD_W] + (mul_reg[0] ? HI_W'(TPS_VAL) : HI_W'(0));
        mul_next = {hi_next, mul_reg[MD_W-1:0]} >> 1;

        // restoring divide step
        shifted  = {rem_reg, dv_reg[STAMP_W-1]};
        trial    = {1'b0, shifted} - {2'b00, freq_eff};
        q_bit    = ~trial[FREQ_W+1];
        rem_next = q_bit ? trial[FREQ_W-1:0] : shifted[FREQ_W-1:0];
        dv_next  = {dv_reg[STAMP_W-2:0], q_bit};

        // serial tick sum
        tsum2 = {1'b0, tick_sum_reg[0]} + {1'b0, elapsed_reg[0]} + {1'b0, carry_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            freq_reg         <= FREQ_RESET;
            maxd_reg         <= MAXD_RESET;
            last_stamp_reg   <= '0;
            accum_reg        <= '0;
            tick_sum_reg     <= '0;
            elapsed_reg      <= '0;
            frame_cnt_reg    <= '0;
            win_frames_reg   <= '0;
            rate_reg         <= '0;
            closed_reg       <= 1'b0;
            stamp_sh_reg     <= '0;
            delta_reg        <= '0;
            freq_sh_reg      <= '0;
            maxd_sh_reg      <= '0;
            borrow_reg       <= 1'b0;
            carry_reg        <= 1'b0;
            gt_reg           <= 1'b0;
            ge_reg           <= 1'b0;
            mul_reg          <= '0;
            dv_reg           <= '0;
            rem_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FREQ: freq_reg <= cfg_data;
                    CFG_MAXD: maxd_reg <= cfg_data[MD_W-1:0];
                    default:  ;
                endcase
            end

            if (load_result)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        step_reg <= '0;
                        if (item.action == ACT_RESTART)
                        begin
                            last_stamp_reg <= item.timestamp;
                            rate_reg       <= '0;
                            win_frames_reg <= '0;
                            accum_reg      <= '0;
                            closed_reg     <= 1'b0;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            stamp_sh_reg <= item.timestamp;
                            freq_sh_reg  <= freq_eff;
                            maxd_sh_reg  <= maxd_reg;
                            borrow_reg   <= 1'b0;
                            carry_reg    <= 1'b0;
                            gt_reg       <= 1'b0;
                            ge_reg       <= 1'b1;    // equal counts as reached
                            state_reg    <= ST_DIFF;
                        end
                    end
                end

                ST_DIFF:
                begin
                    // last_stamp rotates the new stamp in as the old one goes out
                    stamp_sh_reg   <= stamp_sh_reg >> 1;
                    last_stamp_reg <= {stamp_sh_reg[0], last_stamp_reg[STAMP_W-1:1]};
                    accum_reg      <= {acc_bit, accum_reg[STAMP_W-1:1]};
                    delta_reg      <= {d_bit, delta_reg[STAMP_W-1:1]};
                    freq_sh_reg    <= freq_sh_reg >> 1;
                    maxd_sh_reg    <= maxd_sh_reg >> 1;
                    borrow_reg     <= diff2[1];
                    carry_reg      <= sum2[1];
                    gt_reg         <= gt_next;
                    ge_reg         <= ge_next;
                    step_reg       <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        mul_reg        <= {{HI_W{1'b0}}, mplier_next};
                        frame_cnt_reg  <= frame_cnt_reg + 1'b1;
                        win_frames_reg <= win_frames_reg + 1'b1;
                        step_reg       <= '0;
                        state_reg      <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    mul_reg  <= mul_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == MUL_LAST)
                    begin
                        dv_reg    <= STAMP_W'(mul_next);
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    dv_reg   <= dv_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        // quotient is the new elapsed; divider is reused for the modulo
                        elapsed_reg <= dv_next;
                        dv_reg      <= accum_reg;
                        rem_reg     <= '0;
                        carry_reg   <= 1'b0;
                        step_reg    <= '0;
                        state_reg   <= ST_FIN;
                    end
                end

                ST_FIN:
                begin
                    dv_reg       <= dv_next;
                    rem_reg      <= rem_next;
                    tick_sum_reg <= {tsum2[0], tick_sum_reg[STAMP_W-1:1]};
                    elapsed_reg  <= {elapsed_reg[0], elapsed_reg[STAMP_W-1:1]};
                    carry_reg    <= tsum2[1];
                    step_reg     <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        closed_reg <= ge_reg;
                        if (ge_reg)
                        begin
                            accum_reg      <= STAMP_W'(rem_next);
                            rate_reg       <= win_frames_reg;
                            win_frames_reg <= '0;
                        end
                        step_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    if (load_result)
                    begin
                        result_reg.elapsed_ticks     <= elapsed_reg;
                        result_reg.total_ticks       <= tick_sum_reg;
                        result_reg.frame_total       <= frame_cnt_reg;
                        result_reg.frames_per_second <= rate_reg;
                        result_reg.rate_updated      <= closed_reg;
                        state_reg                    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### src/fst_checker.sv
// Port-level checks for the frame step timer, bound to frame_step_timer_core.
`timescale 1ns / 1ps
`include "frame_step_timer_core_defines.svh"

module fst_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_stall,
    input fst_pkg::item_t                   item,
    input logic                             result_valid,
    input logic                             result_stall,
    input fst_pkg::result_t                 result,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [fst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [fst_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fst_pkg::*;

    // held result
    `FST_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result))
    // one transaction in flight: an accepted item blocks the next
    `FST_ASSERT(a_busy_after_accept, item_valid && !item_stall |=> item_stall)
    // a new result only appears after a busy cycle
    `FST_ASSERT(a_result_after_busy, $rose(result_valid) |-> $past(item_stall))
    // leaving busy means a result was just loaded
    `FST_ASSERT(a_free_with_result, $fell(item_stall) |-> result_valid)

endmodule

bind frame_step_timer_core fst_checker u_fst_checker (.*);
